// File: sv/blzd_pkg.sv
// Package for the backward LZSS decompressor: the command and status structs
// that join the controller to the datapath, and the fixed constants of the format.
// Depends on nothing.
`default_nettype none

package blzd_pkg;

  // Format constants.
  localparam logic [7:0]  FLAG_MSB    = 8'h80;
  localparam logic [15:0] DISP_MASK   = 16'h0FFF;
  localparam logic [3:0]  FLAG_COUNT  = 4'd8;
  localparam logic [4:0]  LEN_BIAS    = 5'd3;
  localparam logic [12:0] DISP_BIAS   = 13'd2;
  localparam logic [4:0]  MAX_LEN     = 5'd18;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // latch the accepted input item
    logic load_flags;  // the latched byte is a control byte
    logic store_high;  // the latched byte is the high byte of a pair
    logic start_pair;  // the latched byte is the low byte: load length and distance
    logic read_src;    // issue the first window read of a copy
    logic emit_lit;    // write and emit the latched literal
    logic emit_copy;   // write and emit the byte read from the window, read the next
    logic emit_err;    // emit an error item and halt
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic halted;
    logic pos_zero;
    logic awaiting;
    logic flags_empty;
    logic flag_bit;
    logic in_last;
    logic pos_lt_len;
    logic src_oob;
    logic next_oob;
    logic cnt_one;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: sv/blzd_if.sv
// Handshake interfaces for the compressed input channel and the result channel.
// Depends on nothing.
`default_nettype none

interface blzd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface blzd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [31:0] out_position;
  logic        run_last;
  logic        error_flag;

  modport source (output valid, output out_byte, output out_position, output run_last,
                  output error_flag, input ready);
  modport sink   (input valid, input out_byte, input out_position, input run_last,
                  input error_flag, output ready);
endinterface

`default_nettype wire

// File: sv/backward_lzss_decompressor.sv
// Backward LZSS decompressor: takes one compressed byte per item, from the end of
// the compressed region toward its start, and delivers decompressed bytes with their
// positions, counting down from output_size. Writing cfg_wdata sets output_size and
// starts a new stream. A control byte or pair high byte passes IDLE and EXEC; a
// literal also LIT; a pair low byte also CPRD, then CPWR for each copied byte, fed
// by the history window memory, which gives one byte a cycle through a registered
// read port while the result register is free. An error item ends the stream, as
// does the byte marked last or reaching position zero; later items are taken and
// dropped. Depends on blzd_pkg, blzd_if, blzd_ctrl and blzd_datapath.
`default_nettype none

module backward_lzss_decompressor #(
  parameter int WINDOW_DEPTH = 8192
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  blzd_in_if.sink          in_ch,
  blzd_out_if.source       out_ch
);

  blzd_pkg::cmd_t cmd;
  blzd_pkg::sts_t sts;
  logic           in_ready;

  // Sequencer for one item at a time.
  blzd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign in_ch.ready = in_ready;

  // Stream state, window and result register.
  blzd_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_byte      (in_ch.in_byte),
    .in_last      (in_ch.in_last),
    .cmd          (cmd),
    .sts          (sts),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_byte     (out_ch.out_byte),
    .out_position (out_ch.out_position),
    .run_last     (out_ch.run_last),
    .error_flag   (out_ch.error_flag)
  );

endmodule

`default_nettype wire

// File: sv/blzd_ctrl.sv
// Controller state machine of the backward LZSS decompressor.
// Depends on blzd_pkg for the command and status structs.
`default_nettype none

module blzd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire blzd_pkg::sts_t sts,
  output blzd_pkg::cmd_t     cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_LIT  = 6'b000100,
    S_ERR  = 6'b001000,
    S_CPRD = 6'b010000,
    S_CPWR = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands.
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.halted || sts.pos_zero) begin
          state_nxt = S_IDLE;
        end else if (sts.awaiting) begin
          cmd.start_pair = 1'b1;
          state_nxt      = sts.pos_lt_len ? S_ERR : S_CPRD;
        end else if (sts.flags_empty) begin
          cmd.load_flags = 1'b1;
          state_nxt      = S_IDLE;
        end else if (sts.flag_bit) begin
          cmd.store_high = 1'b1;
          state_nxt      = sts.in_last ? S_ERR : S_IDLE;
        end else begin
          state_nxt = S_LIT;
        end
      end
      S_LIT: begin
        if (sts.out_free) begin
          cmd.emit_lit = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_ERR: begin
        if (sts.out_free) begin
          cmd.emit_err = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_CPRD: begin
        if (sts.src_oob) begin
          state_nxt = S_ERR;
        end else begin
          cmd.read_src = 1'b1;
          state_nxt    = S_CPWR;
        end
      end
      S_CPWR: begin
        if (sts.out_free) begin
          cmd.emit_copy = 1'b1;
          if (sts.cnt_one) begin
            state_nxt = S_IDLE;
          end else if (sts.next_oob) begin
            state_nxt = S_ERR;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: sv/blzd_datapath.sv
// Datapath of the backward LZSS decompressor: stream registers, history window
// memory, bounds checks and the result register. Depends on blzd_pkg.
`default_nettype none

module blzd_datapath #(
  parameter int WINDOW_DEPTH = 8192
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_we,
  input  wire logic [31:0]    cfg_wdata,
  input  wire logic [7:0]     in_byte,
  input  wire logic           in_last,
  input  wire blzd_pkg::cmd_t cmd,
  output blzd_pkg::sts_t      sts,
  input  wire logic           out_ready,
  output logic                out_valid,
  output logic [7:0]          out_byte,
  output logic [31:0]         out_position,
  output logic                run_last,
  output logic                error_flag
);

  localparam int AW = $clog2(WINDOW_DEPTH);

  // Control state.
  logic [31:0]   osize_r, osize_nxt;
  logic [31:0]   pos_r, pos_nxt;
  logic [7:0]    flag_shift_r, flag_shift_nxt;
  logic [3:0]    flags_left_r, flags_left_nxt;
  logic          awaiting_r, awaiting_nxt;
  logic          halted_r, halted_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [AW-1:0] widx_r, widx_nxt;

  // Payload state.
  logic [7:0]    in_byte_r, in_last_byte_nxt;
  logic          in_last_r, in_last_nxt;
  logic [7:0]    pair_hi_r, pair_hi_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic [12:0]   disp_r, disp_nxt;
  logic [7:0]    obyte_r, obyte_nxt;
  logic [31:0]   opos_r, opos_nxt;
  logic          olast_r, olast_nxt;
  logic          oerr_r, oerr_nxt;
  logic [7:0]    rd_data_r;

  // History window memory, indexed by bytes written since the stream start.
  logic [7:0]    mem [WINDOW_DEPTH];

  logic [15:0]   pair_w;
  logic [4:0]    len_w;
  logic [32:0]   src_sum;
  logic [AW-1:0] widx_inc;
  logic [AW-1:0] rd_base;
  logic [AW:0]   rd_diff;
  logic [AW-1:0] rd_idx;
  logic          rd_en;
  logic          wr_en;
  logic [7:0]    wr_data;
  logic          out_free;
  logic          take_flag;

  // Pair decode and address arithmetic.
  assign pair_w   = {pair_hi_r, in_byte_r};
  assign len_w    = 5'(pair_w[15:12]) + blzd_pkg::LEN_BIAS;
  assign src_sum  = {1'b0, pos_r} + 33'(disp_r);
  assign widx_inc = (widx_r == AW'(WINDOW_DEPTH - 1)) ? '0 : widx_r + 1'b1;
  assign rd_base  = cmd.emit_copy ? widx_inc : widx_r;
  assign rd_diff  = {1'b0, rd_base} - (AW + 1)'(disp_r);
  assign rd_idx   = rd_diff[AW] ? AW'(rd_diff + (AW + 1)'(WINDOW_DEPTH)) : rd_diff[AW-1:0];
  assign rd_en    = cmd.read_src | cmd.emit_copy;
  assign wr_en    = cmd.emit_lit | cmd.emit_copy;
  assign wr_data  = cmd.emit_copy ? rd_data_r : in_byte_r;
  assign out_free = !out_valid_r || out_ready;

  // Status to the controller.
  always_comb begin
    sts.halted      = halted_r;
    sts.pos_zero    = (pos_r == '0);
    sts.awaiting    = awaiting_r;
    sts.flags_empty = (flags_left_r == '0);
    sts.flag_bit    = (flag_shift_r & blzd_pkg::FLAG_MSB) != '0;
    sts.in_last     = in_last_r;
    sts.pos_lt_len  = pos_r < 32'(len_w);
    sts.src_oob     = src_sum >= {1'b0, osize_r};
    sts.next_oob    = src_sum > {1'b0, osize_r};
    sts.cnt_one     = (cnt_r == 5'd1);
    sts.out_free    = out_free;
  end

  // Next state of the stream registers and the result register.
  always_comb begin
    osize_nxt        = osize_r;
    pos_nxt          = pos_r;
    flag_shift_nxt   = flag_shift_r;
    flags_left_nxt   = flags_left_r;
    awaiting_nxt     = awaiting_r;
    halted_nxt       = halted_r;
    widx_nxt         = widx_r;
    in_last_byte_nxt = in_byte_r;
    in_last_nxt      = in_last_r;
    pair_hi_nxt      = pair_hi_r;
    cnt_nxt          = cnt_r;
    disp_nxt         = disp_r;
    obyte_nxt        = obyte_r;
    opos_nxt         = opos_r;
    olast_nxt        = olast_r;
    oerr_nxt         = oerr_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    take_flag        = 1'b0;

    if (cmd.capture) begin
      in_last_byte_nxt = in_byte;
      in_last_nxt      = in_last;
    end
    if (cmd.load_flags) begin
      flag_shift_nxt = in_byte_r;
      flags_left_nxt = blzd_pkg::FLAG_COUNT;
      if (in_last_r) begin
        halted_nxt = 1'b1;
      end
    end
    if (cmd.store_high) begin
      pair_hi_nxt  = in_byte_r;
      awaiting_nxt = 1'b1;
    end
    if (cmd.start_pair) begin
      awaiting_nxt = 1'b0;
      cnt_nxt      = len_w;
      disp_nxt     = 13'(pair_w & blzd_pkg::DISP_MASK) + blzd_pkg::DISP_BIAS;
    end
    if (cmd.emit_lit) begin
      pos_nxt       = pos_r - 1'b1;
      widx_nxt      = widx_inc;
      obyte_nxt     = in_byte_r;
      opos_nxt      = pos_r - 1'b1;
      olast_nxt     = 1'b1;
      oerr_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      take_flag     = 1'b1;
      if (in_last_r) begin
        halted_nxt = 1'b1;
      end
    end
    if (cmd.emit_copy) begin
      pos_nxt       = pos_r - 1'b1;
      widx_nxt      = widx_inc;
      cnt_nxt       = cnt_r - 1'b1;
      obyte_nxt     = rd_data_r;
      opos_nxt      = pos_r - 1'b1;
      olast_nxt     = (cnt_r == 5'd1);
      oerr_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      if (cnt_r == 5'd1) begin
        take_flag = 1'b1;
        if (in_last_r) begin
          halted_nxt = 1'b1;
        end
      end
    end
    if (cmd.emit_err) begin
      obyte_nxt     = '0;
      opos_nxt      = pos_r;
      olast_nxt     = 1'b1;
      oerr_nxt      = 1'b1;
      out_valid_nxt = 1'b1;
      halted_nxt    = 1'b1;
    end
    if (take_flag) begin
      flag_shift_nxt = {flag_shift_r[6:0], 1'b0};
      if (flags_left_r != '0) begin
        flags_left_nxt = flags_left_r - 1'b1;
      end
    end

    // A register write starts a new stream.
    if (cfg_we) begin
      osize_nxt      = cfg_wdata;
      pos_nxt        = cfg_wdata;
      flag_shift_nxt = '0;
      flags_left_nxt = '0;
      pair_hi_nxt    = '0;
      awaiting_nxt   = 1'b0;
      halted_nxt     = 1'b0;
      widx_nxt       = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      osize_r      <= '0;
      pos_r        <= '0;
      flag_shift_r <= '0;
      flags_left_r <= '0;
      awaiting_r   <= 1'b0;
      halted_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      widx_r       <= '0;
    end else begin
      osize_r      <= osize_nxt;
      pos_r        <= pos_nxt;
      flag_shift_r <= flag_shift_nxt;
      flags_left_r <= flags_left_nxt;
      awaiting_r   <= awaiting_nxt;
      halted_r     <= halted_nxt;
      out_valid_r  <= out_valid_nxt;
      widx_r       <= widx_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    in_byte_r <= in_last_byte_nxt;
    in_last_r <= in_last_nxt;
    pair_hi_r <= pair_hi_nxt;
    cnt_r     <= cnt_nxt;
    disp_r    <= disp_nxt;
    obyte_r   <= obyte_nxt;
    opos_r    <= opos_nxt;
    olast_r   <= olast_nxt;
    oerr_r    <= oerr_nxt;
  end

  // Window write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[widx_inc] <= wr_data;
    end
  end

  // Window read port with registered data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = obyte_r;
  assign out_position = opos_r;
  assign run_last     = olast_r;
  assign error_flag   = oerr_r;

`ifndef SYNTH
  // The write position only moves down within a stream.
  a_pos_down: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_we |=> pos_r <= $past(pos_r))
    else $error("write position rose without a register write");

  // Once halted, only a register write restarts the stream.
  a_halt_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (halted_r && !cfg_we) |=> halted_r)
    else $error("halt cleared without a register write");

  // An error item always leaves the block halted.
  a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_err && !cfg_we) |=> halted_r)
    else $error("error item emitted without halting");

  // A copy byte is only emitted while bytes of the copy remain.
  a_copy_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_copy |-> (cnt_r != '0) && (cnt_r <= blzd_pkg::MAX_LEN))
    else $error("copy byte emitted outside a copy");

  // The window index stays inside the memory.
  a_widx_range: assert property (@(posedge clk) disable iff (!rst_n)
    widx_r <= AW'(WINDOW_DEPTH - 1))
    else $error("window index out of range");
`endif

endmodule

`default_nettype wire

// File: tb/tb_backward_lzss_decompressor.sv
// Self-checking testbench for the backward LZSS decompressor: directed streams, then random
// well-formed streams with noise, checked against a predictor of the decoding rules.
// Depends on blzd_pkg, blzd_if and backward_lzss_decompressor.
`default_nettype none

module tb_backward_lzss_decompressor;

  localparam int WIN_DEPTH     = 8192;
  localparam int RANDOM_ITEMS  = 300;
  localparam int SETTLE_CYCLES = 30;
  localparam int STALL_LIMIT   = 3000;
  localparam int HOLD_CYCLES   = 80;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [7:0]  data;
    logic [31:0] pos;
    logic        run_last;
    logic        err;
  } blz_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  blzd_in_if  in_ch ();
  blzd_out_if out_ch ();

  backward_lzss_decompressor #(
    .WINDOW_DEPTH(WIN_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always #6 clk = ~clk;

  // Decoder state kept by the testbench.
  logic [7:0]  hist_mem [WIN_DEPTH];
  logic [31:0] size_reg;
  logic [31:0] next_pos;
  logic [7:0]  flag_bits;
  logic [3:0]  flag_count;
  logic [7:0]  pair_hi;
  logic        want_low;
  logic        stream_done;

  blz_result_t expected_bytes[$];
  int          mismatch_count = 0;
  int          decoded_items  = 0;
  int          hold_request   = 0;
  int          stall_cycles   = 0;
  bit          idle_en        = 1'b1;

  // A size write restarts decoding from the top of the buffer.
  function automatic void restart_stream(input logic [31:0] size);
    size_reg    = size;
    next_pos    = size;
    flag_bits   = 8'h00;
    flag_count  = 4'd0;
    pair_hi     = 8'h00;
    want_low    = 1'b0;
    stream_done = 1'b0;
  endfunction

  function automatic void shift_flag();
    flag_bits = flag_bits << 1;
    if (flag_count > 0) flag_count = flag_count - 4'd1;
  endfunction

  // Decodes one compressed byte, queues the bytes it yields and returns 1 unless the
  // block is to drop it.
  function automatic bit decode_byte(input logic [7:0] b, input logic last);
    blz_result_t res[$];
    blz_result_t r;
    logic [15:0] pair;
    logic [4:0]  len;
    logic [12:0] disp;
    logic [32:0] src;
    bit          fail;
    fail = 1'b0;
    if (stream_done || next_pos == 32'd0) return 1'b0;
    if (want_low) begin
      // Low byte of a pair: copy from the produced data, one byte at a time.
      pair     = {pair_hi, b};
      len      = 5'(pair[15:12]) + blzd_pkg::LEN_BIAS;
      disp     = 13'(pair & blzd_pkg::DISP_MASK) + blzd_pkg::DISP_BIAS;
      want_low = 1'b0;
      if (next_pos < 32'(len)) begin
        fail = 1'b1;
      end else begin
        for (int j = 0; j < int'(len) && !fail; j++) begin
          src = {1'b0, next_pos} + 33'(disp);
          if (src >= {1'b0, size_reg}) begin
            fail = 1'b1;
          end else begin
            r.data     = hist_mem[src % WIN_DEPTH];
            next_pos   = next_pos - 32'd1;
            hist_mem[next_pos % WIN_DEPTH] = r.data;
            r.pos      = next_pos;
            r.run_last = 1'b0;
            r.err      = 1'b0;
            res.push_back(r);
          end
        end
      end
      if (!fail) shift_flag();
    end else if (flag_count == 4'd0) begin
      // Control byte: no output.
      flag_bits  = b;
      flag_count = blzd_pkg::FLAG_COUNT;
      if (last) stream_done = 1'b1;
      return 1'b1;
    end else if ((flag_bits & blzd_pkg::FLAG_MSB) != 8'h00) begin
      pair_hi  = b;
      want_low = 1'b1;
      if (last) fail = 1'b1;
    end else begin
      // Literal.
      next_pos   = next_pos - 32'd1;
      hist_mem[next_pos % WIN_DEPTH] = b;
      r.data     = b;
      r.pos      = next_pos;
      r.run_last = 1'b0;
      r.err      = 1'b0;
      res.push_back(r);
      shift_flag();
    end

    if (fail) begin
      r.data     = 8'h00;
      r.pos      = next_pos;
      r.run_last = 1'b0;
      r.err      = 1'b1;
      res.push_back(r);
      stream_done = 1'b1;
    end else if (last) begin
      stream_done = 1'b1;
    end
    if (res.size() > 0) res[res.size() - 1].run_last = 1'b1;
    foreach (res[i]) expected_bytes.push_back(res[i]);
    return 1'b1;
  endfunction

  // Offers one item, with an occasional gap before it, and waits until it is taken.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (decode_byte(b, last)) decoded_items++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  // The size register is only written once the block has gone quiet.
  task automatic set_output_size(input logic [31:0] size);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= size;
    @(posedge clk);
    cfg_we    <= 1'b0;
    restart_stream(size);
  endtask

  task automatic test_zero_size();
    set_output_size(32'd0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
  endtask

  // Literals around a shortest copy at the nearest distance and a longest copy.
  task automatic test_copies();
    set_output_size(32'd30);
    send_byte(8'h18, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h5A, 1'b1);
  endtask

  // A copy longer than the space left gives a lone error item.
  task automatic test_copy_overrun();
    set_output_size(32'd8);
    send_byte(8'h20, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  // Largest size with the farthest distance: the source lies beyond the buffer.
  task automatic test_source_out_of_range();
    set_output_size(32'hFFFF_FFFF);
    send_byte(8'h40, 1'b0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'hFF, 1'b0);
  endtask

  task automatic test_truncated_pair();
    set_output_size(32'd16);
    send_byte(8'h80, 1'b0);
    send_byte(8'h12, 1'b1);
  endtask

  // A control byte marked last ends the stream without output; later items are dropped.
  task automatic test_last_control();
    set_output_size(32'd16);
    send_byte(8'h00, 1'b1);
    send_byte(8'h11, 1'b0);
  endtask

  // Once position zero is reached further items are dropped.
  task automatic test_position_zero();
    set_output_size(32'd2);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7E, 1'b0);
    send_byte(8'h81, 1'b0);
    send_byte(8'h42, 1'b0);
  endtask

  // Long copies while the receiver holds off, so that the block backs up its input.
  task automatic test_backpressure();
    set_output_size(32'd400);
    hold_request = HOLD_CYCLES;
    send_byte(8'h1F, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    for (int i = 0; i < 5; i++) begin
      send_byte(8'hF0, 1'b0);
      send_byte(8'(i), 1'b0);
    end
    send_byte(8'hFF, 1'b0);
    for (int i = 0; i < 8; i++) begin
      send_byte(8'hF0 | 8'(i), 1'b0);
      send_byte(8'($urandom), 1'b0);
    end
  endtask

  // Mostly well-formed streams with random content; some pairs are random, some items
  // carry an early last, and a few items are sent after the stream has ended.
  task automatic run_random_stream(input int budget);
    int          sent;
    int          produced;
    int          max_len;
    int          max_disp;
    logic [15:0] pair;
    logic [7:0]  low_byte;
    logic [7:0]  b;
    logic        last;
    sent     = 0;
    low_byte = 8'h00;
    while (sent < budget && !stream_done && next_pos != 32'd0) begin
      last     = ($urandom_range(0, 39) == 0);
      produced = int'(size_reg - next_pos);
      if (want_low) begin
        b = low_byte;
      end else if (flag_count == 4'd0) begin
        // The first control byte of a stream starts with literals.
        b = (produced == 0) ? 8'($urandom_range(0, 31)) : 8'($urandom_range(0, 255));
      end else if ((flag_bits & blzd_pkg::FLAG_MSB) != 8'h00) begin
        max_len = (next_pos < 32'd18) ? int'(next_pos) : 18;
        if (produced < 3 || max_len < 3 || $urandom_range(0, 11) == 0) begin
          pair = 16'($urandom);
        end else begin
          max_disp = (produced - 3 < 4095) ? produced - 3 : 4095;
          pair = {4'($urandom_range(0, max_len - 3)), 12'($urandom_range(0, max_disp))};
        end
        b        = pair[15:8];
        low_byte = pair[7:0];
      end else begin
        b = 8'($urandom);
      end
      send_byte(b, last);
      sent++;
    end
    if ($urandom_range(0, 2) == 0) send_byte(8'($urandom), 1'($urandom));
  endtask

  task automatic test_random_streams();
    int          start;
    logic [31:0] size;
    start = decoded_items;
    while (decoded_items - start < RANDOM_ITEMS) begin
      if (decoded_items - start >= RANDOM_ITEMS * 4 / 5) idle_en = 1'b0;
      case ($urandom_range(0, 7))
        0: begin
          size = 32'($urandom);
        end
        1: begin
          size = 32'($urandom_range(1, 8));
        end
        default: begin
          size = 32'($urandom_range(20, 250));
        end
      endcase
      set_output_size(size);
      run_random_stream($urandom_range(10, 60));
    end
  endtask

  // Receiver: random short stalls, and a long hold-off when one is requested.
  initial begin : result_sink
    int n;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3) - 1) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Each result item is compared with the oldest expected one.
  always @(posedge clk) begin : result_check
    blz_result_t got;
    blz_result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.data     = out_ch.out_byte;
      got.pos      = out_ch.out_position;
      got.run_last = out_ch.run_last;
      got.err      = out_ch.error_flag;
      if (expected_bytes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("Unexpected result: byte %h pos %h last %b err %b",
                   got.data, got.pos, got.run_last, got.err);
      end else begin
        want = expected_bytes.pop_front();
        if (got.data !== want.data || got.pos !== want.pos ||
            got.run_last !== want.run_last || got.err !== want.err) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("Mismatch: expected %h pos %h last %b err %b, got %h pos %h last %b err %b",
                     want.data, want.pos, want.run_last, want.err,
                     got.data, got.pos, got.run_last, got.err);
        end
      end
    end
  end

  // Watchdog on cycles in which no item moves on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Reset, the directed tests, the random streams, then the final verdict.
  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = 32'd0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.in_last = 1'b0;
    foreach (hist_mem[i]) hist_mem[i] = 8'h00;
    restart_stream(32'd0);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_zero_size();
    test_copies();
    test_copy_overrun();
    test_source_out_of_range();
    test_truncated_pair();
    test_last_control();
    test_position_zero();
    test_backpressure();
    test_random_streams();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: backward_lzss_decompressor.f
sv/blzd_pkg.sv
sv/blzd_if.sv
sv/blzd_ctrl.sv
sv/blzd_datapath.sv
sv/backward_lzss_decompressor.sv
tb/tb_backward_lzss_decompressor.sv
